>>> design/serial_bank_switch_mapper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial bank switch mapper
// Shorthand for clocked implications, used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_BANK_SWITCH_MAPPER_ASSERT_SVH
`define SERIAL_BANK_SWITCH_MAPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbsm assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SBSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbsm assertion failed in the following cycle");

`endif

>>> design/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper package
// Shared types and constants for the mapper and its remainder unit.
// ----------------------------------------------------------------------------
package sbsm_pkg;

   // Result targets.
   localparam logic [2:0] TGT_NONE_FF = 3'd0;
   localparam logic [2:0] TGT_NONE_00 = 3'd1;
   localparam logic [2:0] TGT_PRG_ROM = 3'd2;
   localparam logic [2:0] TGT_PRG_RAM = 3'd3;
   localparam logic [2:0] TGT_CHR_ROM = 3'd4;
   localparam logic [2:0] TGT_CHR_RAM = 3'd5;
   localparam logic [2:0] TGT_NAMETAB = 3'd6;
   localparam logic [2:0] TGT_PALETTE = 3'd7;

   // Access kinds.
   localparam logic [1:0] REQ_CPU_RD = 2'd0;
   localparam logic [1:0] REQ_CPU_WR = 2'd1;
   localparam logic [1:0] REQ_PPU_RD = 2'd2;
   localparam logic [1:0] REQ_PPU_WR = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_PRG_BANKS = 1'b0;
   localparam logic CSR_CHR_BANKS = 1'b1;

   // Bank count limits and reset values.
   localparam logic [4:0] MAX_PRG_BANKS   = 5'd16;
   localparam logic [5:0] MAX_CHR_BANKS   = 6'd32;
   localparam logic [4:0] PRG_BANKS_RESET = 5'd2;
   localparam logic [5:0] CHR_BANKS_RESET = 6'd0;
   localparam logic [4:0] SHIFT_RESET     = 5'h10;
   localparam logic [4:0] CONTROL_RESET   = 5'h0C;
   localparam logic [4:0] CONTROL_MODE3   = 5'h0C;
   localparam logic [3:0] WIN_HI_RESET    = 4'd1;
   localparam logic [2:0] SERIAL_LAST     = 3'd4;
   localparam logic [5:0] PALETTE_PAGE    = 6'h3F;

   // Remainder unit: one dividend bit per step.
   localparam logic [2:0] DIV_STEPS = 3'd5;

   typedef struct packed {
      logic       start;
      logic [4:0] dividend;
      logic [5:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [4:0] remainder;
   } div_rsp_type;

endpackage

>>> design/sbsm_mod.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper remainder unit
// Restoring remainder of a 5-bit value by a non-zero 6-bit divisor, one
// dividend bit per cycle; done pulses for one cycle when it is ready.
// ----------------------------------------------------------------------------
module sbsm_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  sbsm_pkg::div_req_type div_req,
   output sbsm_pkg::div_rsp_type div_rsp
);
   import sbsm_pkg::*;

   logic [4:0] rem_ff, rem_in;
   logic [4:0] num_ff, num_in;
   logic [5:0] den_ff, den_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [5:0] trial;
   logic [5:0] diff;

   assign trial = {rem_ff, num_ff[4]};
   assign diff  = trial - den_ff;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         num_in  = div_req.dividend;
         den_in  = div_req.divisor;
         cnt_in  = DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = (trial >= den_ff) ? diff[4:0] : trial[4:0];
         num_in = {num_ff[3:0], 1'b0};
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> design/serial_bank_switch_mapper.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper
// Maps CPU and PPU bus accesses onto program ROM, work RAM, pattern ROM or
// RAM, nametables and palette, and runs the 5-bit serial register loader.
// ----------------------------------------------------------------------------
// Each access gives one result. Pattern ROM accesses, and loader writes that
// commit a register or reset the loader, use the shared remainder unit,
// which retires one bit per cycle over five steps; with no program ROM such
// loader writes skip it. A write of the program bank count keeps the mapper
// busy while the window banks are recomputed by the same unit, or cleared
// when the count is zero. A finished result waits in the output register
// while the next access is taken in.
module serial_bank_switch_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_target,
   output logic [17:0] rsp_mem_offset,
   output logic        rsp_mem_write,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);
   import sbsm_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_FLUSH} state_type;
   typedef enum logic [1:0] {JOB_WIN_CSR, JOB_WIN_REQ, JOB_CHR} job_type;

   state_type   state_ff, state_in;
   job_type     job_ff, job_in;
   logic [12:0] addr_ff, addr_in;
   logic [4:0]  shift_ff, shift_in;
   logic [2:0]  count_ff, count_in;
   logic [4:0]  control_ff, control_in;
   logic [4:0]  chr_lo_ff, chr_lo_in;
   logic [4:0]  chr_hi_ff, chr_hi_in;
   logic [3:0]  bank_sel_ff, bank_sel_in;
   logic        wram_en_ff, wram_en_in;
   logic [3:0]  win_lo_ff, win_lo_in;
   logic [3:0]  win_hi_ff, win_hi_in;
   logic [4:0]  prg_count_ff, prg_count_in;
   logic [5:0]  chr_banks_ff, chr_banks_in;
   logic [2:0]  res_target_ff, res_target_in;
   logic [17:0] res_offset_ff, res_offset_in;
   logic        res_write_ff, res_write_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_target_ff, rsp_target_in;
   logic [17:0] rsp_offset_ff, rsp_offset_in;
   logic        rsp_write_ff, rsp_write_in;

   logic [4:0]  prg_n;
   logic [5:0]  chr_n;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign prg_n = (prg_count_ff > MAX_PRG_BANKS) ? MAX_PRG_BANKS : prg_count_ff;
   assign chr_n = (chr_banks_ff > MAX_CHR_BANKS) ? MAX_CHR_BANKS : chr_banks_ff;

   sbsm_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      logic [4:0]  shift_new;
      logic [13:0] ppu_addr;
      logic        is_wr;
      logic        nt_hi;
      logic [4:0]  pal_idx;
      logic [4:0]  rem;
      logic [4:0]  rem_next;
      logic [4:0]  last_bank;

      state_in      = state_ff;
      job_in        = job_ff;
      addr_in       = addr_ff;
      shift_in      = shift_ff;
      count_in      = count_ff;
      control_in    = control_ff;
      chr_lo_in     = chr_lo_ff;
      chr_hi_in     = chr_hi_ff;
      bank_sel_in   = bank_sel_ff;
      wram_en_in    = wram_en_ff;
      win_lo_in     = win_lo_ff;
      win_hi_in     = win_hi_ff;
      prg_count_in  = prg_count_ff;
      chr_banks_in  = chr_banks_ff;
      res_target_in = res_target_ff;
      res_offset_in = res_offset_ff;
      res_write_in  = res_write_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_target_in = rsp_target_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_write_in  = rsp_write_ff;
      div_req       = '0;

      shift_new = {req_data[0], shift_ff[4:1]};
      ppu_addr  = req_addr[13:0];
      is_wr     = (req_type == REQ_PPU_WR);
      case (control_ff[1:0])
         2'd0:    nt_hi = 1'b0;
         2'd1:    nt_hi = 1'b1;
         2'd2:    nt_hi = ppu_addr[10];
         default: nt_hi = ppu_addr[11];
      endcase
      pal_idx = ppu_addr[4:0];
      if (pal_idx[1:0] == 2'd0) begin
         pal_idx[4] = 1'b0;
      end
      rem       = div_rsp.remainder;
      rem_next  = rem + 5'd1;
      last_bank = prg_n - 5'd1;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               if (csr_index == CSR_PRG_BANKS) begin
                  prg_count_in = csr_wdata[4:0];
                  job_in       = JOB_WIN_CSR;
                  state_in     = ST_START;
               end else begin
                  chr_banks_in = csr_wdata;
               end
            end else if (req_valid) begin
               res_target_in = TGT_NONE_FF;
               res_offset_in = '0;
               res_write_in  = 1'b0;
               state_in      = ST_FLUSH;
               if (!req_type[1]) begin
                  if (req_addr[15:13] == 3'b011) begin
                     res_target_in = TGT_PRG_RAM;
                     res_offset_in = {5'd0, req_addr[12:0]};
                     res_write_in  = (req_type == REQ_CPU_WR) && wram_en_ff;
                  end else if (req_addr[15]) begin
                     if (req_type == REQ_CPU_WR) begin
                        if (req_data[7]) begin
                           shift_in   = SHIFT_RESET;
                           count_in   = '0;
                           control_in = control_ff | CONTROL_MODE3;
                           job_in     = JOB_WIN_REQ;
                           state_in   = ST_START;
                        end else if (count_ff == SERIAL_LAST) begin
                           case (req_addr[14:13])
                              2'd0:    control_in = shift_new;
                              2'd1:    chr_lo_in  = shift_new;
                              2'd2:    chr_hi_in  = shift_new;
                              default: begin
                                 bank_sel_in = shift_new[3:0];
                                 wram_en_in  = !shift_new[4];
                              end
                           endcase
                           shift_in = SHIFT_RESET;
                           count_in = '0;
                           job_in   = JOB_WIN_REQ;
                           state_in = ST_START;
                        end else begin
                           shift_in = shift_new;
                           count_in = count_ff + 3'd1;
                        end
                     end else if (prg_n != 5'd0) begin
                        res_target_in = TGT_PRG_ROM;
                        res_offset_in = {req_addr[14] ? win_hi_ff : win_lo_ff,
                                         req_addr[13:0]};
                     end
                  end
               end else begin
                  if (!ppu_addr[13]) begin
                     if (chr_n == 6'd0) begin
                        res_target_in = TGT_CHR_RAM;
                        res_offset_in = {5'd0, ppu_addr[12:0]};
                        res_write_in  = is_wr;
                     end else if (!control_ff[4] && (chr_n[5:1] == 5'd0)) begin
                        res_target_in = TGT_NONE_00;
                     end else begin
                        res_target_in = TGT_CHR_ROM;
                        addr_in       = ppu_addr[12:0];
                        job_in        = JOB_CHR;
                        state_in      = ST_START;
                     end
                  end else if (ppu_addr[13:8] != PALETTE_PAGE) begin
                     res_target_in = TGT_NAMETAB;
                     res_offset_in = {7'd0, nt_hi, ppu_addr[9:0]};
                     res_write_in  = is_wr;
                  end else begin
                     res_target_in = TGT_PALETTE;
                     res_offset_in = {13'd0, pal_idx};
                     res_write_in  = is_wr;
                  end
               end
            end
         end
         ST_START: begin
            if (job_ff == JOB_CHR) begin
               div_req.start = 1'b1;
               state_in      = ST_WAIT;
               if (!control_ff[4]) begin
                  div_req.dividend = {1'b0, chr_lo_ff[4:1]};
                  div_req.divisor  = {1'b0, chr_n[5:1]};
               end else begin
                  div_req.dividend = addr_ff[12] ? chr_hi_ff : chr_lo_ff;
                  div_req.divisor  = chr_n;
               end
            end else if (prg_n == 5'd0) begin
               win_lo_in = '0;
               win_hi_in = '0;
               state_in  = (job_ff == JOB_WIN_CSR) ? ST_IDLE : ST_FLUSH;
            end else begin
               div_req.start    = 1'b1;
               div_req.divisor  = {1'b0, prg_n};
               div_req.dividend = control_ff[3] ? {1'b0, bank_sel_ff}
                                                : {1'b0, bank_sel_ff[3:1], 1'b0};
               state_in         = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               if (job_ff == JOB_CHR) begin
                  if (!control_ff[4]) begin
                     res_offset_in = {1'b0, rem[3:0], addr_ff};
                  end else begin
                     res_offset_in = {1'b0, rem, addr_ff[11:0]};
                  end
                  state_in = ST_FLUSH;
               end else begin
                  case (control_ff[3:2])
                     2'd2: begin
                        win_lo_in = '0;
                        win_hi_in = rem[3:0];
                     end
                     2'd3: begin
                        win_lo_in = rem[3:0];
                        win_hi_in = last_bank[3:0];
                     end
                     default: begin
                        win_lo_in = rem[3:0];
                        win_hi_in = (rem_next == prg_n) ? 4'd0 : rem_next[3:0];
                     end
                  endcase
                  state_in = (job_ff == JOB_WIN_CSR) ? ST_IDLE : ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_target_in = res_target_ff;
               rsp_offset_in = res_offset_ff;
               rsp_write_in  = res_write_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_WIN_CSR;
         shift_ff     <= SHIFT_RESET;
         count_ff     <= '0;
         control_ff   <= CONTROL_RESET;
         chr_lo_ff    <= '0;
         chr_hi_ff    <= '0;
         bank_sel_ff  <= '0;
         wram_en_ff   <= 1'b1;
         win_lo_ff    <= '0;
         win_hi_ff    <= WIN_HI_RESET;
         prg_count_ff <= PRG_BANKS_RESET;
         chr_banks_ff <= CHR_BANKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         control_ff   <= control_in;
         chr_lo_ff    <= chr_lo_in;
         chr_hi_ff    <= chr_hi_in;
         bank_sel_ff  <= bank_sel_in;
         wram_en_ff   <= wram_en_in;
         win_lo_ff    <= win_lo_in;
         win_hi_ff    <= win_hi_in;
         prg_count_ff <= prg_count_in;
         chr_banks_ff <= chr_banks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      res_target_ff <= res_target_in;
      res_offset_ff <= res_offset_in;
      res_write_ff  <= res_write_in;
      rsp_target_ff <= rsp_target_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_write_ff  <= rsp_write_in;
   end

   assign req_ready      = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_target     = rsp_target_ff;
   assign rsp_mem_offset = rsp_offset_ff;
   assign rsp_mem_write  = rsp_write_ff;

endmodule

>>> design/sbsm_checker.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper port checker
// Watches the mapper's ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "serial_bank_switch_mapper_assert.svh"

module sbsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_type,
   input logic [15:0] req_addr,
   input logic [7:0]  req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_target,
   input logic [17:0] rsp_mem_offset,
   input logic        rsp_mem_write,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        csr_index,
   input logic [5:0]  csr_wdata
);
   import sbsm_pkg::*;

   logic rsp_hold;
   logic req_xfer;
   logic chr_cfg_xfer;
   logic writable;

   assign rsp_hold     = rsp_valid && !rsp_ready;
   assign req_xfer     = req_valid && req_ready;
   assign chr_cfg_xfer = csr_valid && csr_ready && (csr_index == CSR_CHR_BANKS);
   assign writable     = (rsp_target == TGT_PRG_RAM) || (rsp_target == TGT_CHR_RAM) ||
                         (rsp_target == TGT_NAMETAB) || (rsp_target == TGT_PALETTE);

   `SBSM_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_hold,
      rsp_valid && $stable(rsp_target) && $stable(rsp_mem_offset) && $stable(rsp_mem_write))
   `SBSM_ASSERT_SAME(a_req_implies_csr, clock, reset, req_ready, csr_ready)
   `SBSM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_ready && !csr_ready)
   `SBSM_ASSERT_NEXT(a_chr_cfg_no_stall, clock, reset, chr_cfg_xfer, csr_ready)
   `SBSM_ASSERT_SAME(a_write_target, clock, reset, rsp_valid && rsp_mem_write, writable)

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (.*);

>>> tb/sv/serial_bank_switch_mapper_checker.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper checker
// Watches the access, result and register channels of the mapper, keeps its
// own copy of the loader, bank and window state, predicts the mapping of
// every accepted access and compares each result transfer, in order, with it.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_target,
   input  logic [17:0] rsp_mem_offset,
   input  logic        rsp_mem_write,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata,
   output int          fail_count,
   output int          pending_results,
   output int          checked_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import sbsm_pkg::*;

   localparam logic [1:0] PRG_MODE_32K_A    = 2'd0;
   localparam logic [1:0] PRG_MODE_32K_B    = 2'd1;
   localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
   localparam logic [1:0] MIRROR_SINGLE_LO  = 2'd0;
   localparam logic [1:0] MIRROR_SINGLE_HI  = 2'd1;
   localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
   localparam logic [1:0] DEST_CONTROL      = 2'd0;
   localparam logic [1:0] DEST_CHR_LO       = 2'd1;
   localparam logic [1:0] DEST_CHR_HI       = 2'd2;

   typedef struct packed {
      logic [2:0]  target;
      logic [17:0] offset;
      logic        write;
   } mapping_type;

   logic [4:0]  prg_count_cfg;
   logic [5:0]  chr_banks_cfg;
   logic [4:0]  loader_shift;
   logic [2:0]  loader_count;
   logic [4:0]  control;
   logic [4:0]  chr_bank_lo;
   logic [4:0]  chr_bank_hi;
   logic [3:0]  bank_reg;
   logic        wram_enable;
   logic [3:0]  window_lo;
   logic [3:0]  window_hi;
   mapping_type expected_q [$];
   int          fails = 0;
   int          checked = 0;

   function automatic int prg_limit();
      return (prg_count_cfg > MAX_PRG_BANKS) ? int'(MAX_PRG_BANKS) : int'(prg_count_cfg);
   endfunction

   function automatic int chr_limit();
      return (chr_banks_cfg > MAX_CHR_BANKS) ? int'(MAX_CHR_BANKS) : int'(chr_banks_cfg);
   endfunction

   function automatic void rederive_windows();
      int n;
      int bank_sel;
      int even;
      n = prg_limit();
      bank_sel = bank_reg;
      if (n == 0) begin
         window_lo = '0;
         window_hi = '0;
      end else begin
         case (control[3:2])
            PRG_MODE_32K_A, PRG_MODE_32K_B: begin
               even = (bank_sel & 'hE) % n;
               window_lo = 4'(even);
               window_hi = 4'((even + 1) % n);
            end
            PRG_MODE_FIX_LOW: begin
               window_lo = '0;
               window_hi = 4'(bank_sel % n);
            end
            default: begin
               window_lo = 4'(bank_sel % n);
               window_hi = 4'(n - 1);
            end
         endcase
      end
   endfunction

   function automatic void reset_model();
      prg_count_cfg = PRG_BANKS_RESET;
      chr_banks_cfg = CHR_BANKS_RESET;
      loader_shift  = SHIFT_RESET;
      loader_count  = '0;
      control       = CONTROL_RESET;
      chr_bank_lo   = '0;
      chr_bank_hi   = '0;
      bank_reg      = '0;
      wram_enable   = 1'b1;
      rederive_windows();
   endfunction

   function automatic void loader_write(logic [15:0] addr, logic [7:0] data);
      if (data[7]) begin
         loader_shift = SHIFT_RESET;
         loader_count = '0;
         control = control | CONTROL_MODE3;
         rederive_windows();
      end else begin
         loader_shift = {data[0], loader_shift[4:1]};
         if (loader_count == SERIAL_LAST) begin
            case (addr[14:13])
               DEST_CONTROL: control = loader_shift;
               DEST_CHR_LO:  chr_bank_lo = loader_shift;
               DEST_CHR_HI:  chr_bank_hi = loader_shift;
               default: begin
                  bank_reg = loader_shift[3:0];
                  wram_enable = ~loader_shift[4];
               end
            endcase
            loader_shift = SHIFT_RESET;
            loader_count = '0;
            rederive_windows();
         end else begin
            loader_count = loader_count + 3'd1;
         end
      end
   endfunction

   function automatic mapping_type map_access(logic [1:0] kind, logic [15:0] addr,
                                              logic [7:0] data);
      mapping_type m;
      int          n;
      int          bank;
      logic [13:0] ppu_addr;
      logic [4:0]  pal;
      logic        page;
      m = '0;
      m.target = TGT_NONE_FF;
      if (kind == REQ_CPU_RD || kind == REQ_CPU_WR) begin
         if (addr[15:13] == 3'b011) begin
            m.target = TGT_PRG_RAM;
            m.offset = {5'd0, addr[12:0]};
            m.write = (kind == REQ_CPU_WR) && wram_enable;
         end else if (addr[15]) begin
            if (kind == REQ_CPU_WR) begin
               loader_write(addr, data);
            end else if (prg_limit() != 0) begin
               n = prg_limit();
               bank = addr[14] ? window_hi : window_lo;
               m.target = TGT_PRG_ROM;
               m.offset = 18'((bank % n) * 'h4000 + addr[13:0]);
            end
         end
      end else begin
         ppu_addr = addr[13:0];
         if (!ppu_addr[13]) begin
            n = chr_limit();
            if (n == 0) begin
               m.target = TGT_CHR_RAM;
               m.offset = {5'd0, ppu_addr[12:0]};
               m.write = (kind == REQ_PPU_WR);
            end else if (!control[4]) begin
               if (n / 2 == 0) begin
                  m.target = TGT_NONE_00;
               end else begin
                  bank = chr_bank_lo[4:1];
                  m.target = TGT_CHR_ROM;
                  m.offset = 18'((bank % (n / 2)) * 'h2000 + ppu_addr[12:0]);
               end
            end else begin
               bank = ppu_addr[12] ? chr_bank_hi : chr_bank_lo;
               m.target = TGT_CHR_ROM;
               m.offset = 18'((bank % n) * 'h1000 + ppu_addr[11:0]);
            end
         end else if (ppu_addr[13:8] != PALETTE_PAGE) begin
            case (control[1:0])
               MIRROR_SINGLE_LO: page = 1'b0;
               MIRROR_SINGLE_HI: page = 1'b1;
               MIRROR_VERTICAL:  page = ppu_addr[10];
               default:          page = ppu_addr[11];
            endcase
            m.target = TGT_NAMETAB;
            m.offset = {7'd0, page, ppu_addr[9:0]};
            m.write = (kind == REQ_PPU_WR);
         end else begin
            pal = ppu_addr[4:0];
            if (pal[1:0] == 2'b00) pal[4] = 1'b0;
            m.target = TGT_PALETTE;
            m.offset = {13'd0, pal};
            m.write = (kind == REQ_PPU_WR);
         end
      end
      return m;
   endfunction

   always @(posedge clock) begin : monitor
      mapping_type seen;
      mapping_type want;
      if (reset) begin
         reset_model();
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_target, rsp_mem_offset, rsp_mem_write};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, %s %0d offset %05h write %0b",
                        $time, "got target", seen.target, seen.offset, seen.write);
               fails++;
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (seen !== want) begin
                  $display("%0t: mismatch, expected target %0d offset %05h write %0b,",
                           $time, want.target, want.offset, want.write);
                  $display("%0t: got target %0d offset %05h write %0b",
                           $time, seen.target, seen.offset, seen.write);
                  fails++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PRG_BANKS) begin
               prg_count_cfg = csr_wdata[4:0];
               rederive_windows();
            end else begin
               chr_banks_cfg = csr_wdata;
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(map_access(req_type, req_addr, req_data));
      end
      pending_results <= expected_q.size();
      fail_count <= fails;
      checked_results <= checked;
   end

endmodule

>>> tb/sv/serial_bank_switch_mapper_test.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper testbench
// Drives directed and random CPU and PPU accesses, loader sequences and bank
// count writes into the mapper under three handshake idle profiles and one
// long result stall, and reports the verdict from the checker beside it.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sbsm_pkg::*;

   localparam int PHASES        = 9;
   localparam int PHASE_ITEMS   = 172;
   localparam int STALL_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = '0;
   logic [15:0] req_addr = '0;
   logic [7:0]  req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_target;
   logic [17:0] rsp_mem_offset;
   logic        rsp_mem_write;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [5:0]  csr_wdata = '0;

   int fail_count;
   int pending_results;
   int checked_results;
   int items_sent = 0;
   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int stall_trigger = 0;
   int stall_seen = 0;
   int stall_left = 0;

   logic [4:0] prg_settings [0:PHASES-1] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd3,
                                            5'd5, 5'd2, 5'd16, 5'd9};
   logic [5:0] chr_settings [0:PHASES-1] = '{6'd1, 6'd32, 6'd2, 6'd63, 6'd0,
                                            6'd7, 6'd12, 6'd33, 6'd1};

   serial_bank_switch_mapper dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_addr       (req_addr),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_target     (rsp_target),
      .rsp_mem_offset (rsp_mem_offset),
      .rsp_mem_write  (rsp_mem_write),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   serial_bank_switch_mapper_checker mapping_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_addr        (req_addr),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_target      (rsp_target),
      .rsp_mem_offset  (rsp_mem_offset),
      .rsp_mem_write   (rsp_mem_write),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .checked_results (checked_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_trigger != stall_seen) begin
         stall_seen <= stall_trigger;
         stall_left <= STALL_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   task automatic send_access(input logic [1:0] kind, input logic [15:0] addr,
                              input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_addr <= addr;
      req_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Five serial writes, least significant bit first; the register is chosen
   // by the address of the last write.
   task automatic load_register(input logic [15:0] base, input logic [4:0] value);
      for (int i = 0; i < 5; i++)
         send_access(REQ_CPU_WR, {base[15:13], 13'($urandom)},
                     {1'b0, 6'($urandom), value[i]});
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [5:0] value);
      req_valid <= 1'b0;
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_burst();
      int          pick;
      logic [1:0]  kind;
      logic [15:0] addr;
      pick = $urandom_range(99);
      kind = 2'($urandom);
      if (pick < 30) begin
         addr = {1'b1, 2'($urandom), 13'd0};
         if ($urandom_range(1) == 0)
            send_access(REQ_CPU_WR, 16'h8000 | 16'($urandom), 8'h80 | 8'($urandom));
         load_register(addr, 5'($urandom));
      end else if (pick < 88) begin
         if (kind == REQ_CPU_WR)
            addr = {3'b011, 13'($urandom)};
         else if (kind == REQ_CPU_RD && $urandom_range(3) != 0)
            addr = 16'($urandom_range(16'hFFFF, 16'h6000));
         else
            addr = 16'($urandom);
         send_access(kind, addr, 8'($urandom));
      end else begin
         send_access(kind, 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int phase_end;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 16;
      take_idle_pct <= 69;
      @(posedge clock);

      send_access(REQ_CPU_RD, 16'h0000, 8'h00);
      send_access(REQ_CPU_WR, 16'h5FFF, 8'hFF);
      send_access(REQ_CPU_RD, 16'h6000, 8'h00);
      send_access(REQ_CPU_WR, 16'h7FFF, 8'hA5);
      send_access(REQ_CPU_RD, 16'h8000, 8'h00);
      send_access(REQ_CPU_RD, 16'hFFFF, 8'h00);
      send_access(REQ_CPU_WR, 16'h8000, 8'h80);
      load_register(16'hE000, 5'h13);
      send_access(REQ_CPU_WR, 16'h6123, 8'h5A);
      send_access(REQ_CPU_RD, 16'hBFFF, 8'h00);
      send_access(REQ_PPU_RD, 16'h0000, 8'h00);
      send_access(REQ_PPU_WR, 16'h1FFF, 8'hFF);
      send_access(REQ_PPU_RD, 16'h2000, 8'h00);
      send_access(REQ_PPU_WR, 16'h2FFF, 8'h3C);
      send_access(REQ_PPU_RD, 16'h3F10, 8'h00);
      send_access(REQ_PPU_WR, 16'h3F1F, 8'hFF);
      send_access(REQ_PPU_RD, 16'hFF1C, 8'h00);
      load_register(16'h8000, 5'h1F);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 3)
            0: begin
               send_idle_pct = 16;
               take_idle_pct <= 69;
            end
            1: begin
               send_idle_pct = 69;
               take_idle_pct <= 16;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct <= 0;
            end
         endcase
         write_reg(CSR_PRG_BANKS, {1'b0, prg_settings[phase]});
         write_reg(CSR_CHR_BANKS, chr_settings[phase]);
         if (phase == PHASES - 2) stall_trigger <= stall_trigger + 1;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) random_burst();
      end

      req_valid <= 1'b0;
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d accesses over %0d bank count settings, three idle profiles",
               checked_results, PHASES + 1);
      $display("and one long result stall with the access channel held full.");
      if (fail_count == 0) begin
         $display("PASS serial_bank_switch_mapper");
      end else begin
         $display("FAIL serial_bank_switch_mapper");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("FAIL serial_bank_switch_mapper");
      $finish;
   end

endmodule
